// ===== hdl/aic_pkg.sv =====
package aic_pkg;

    // Request codes
    typedef enum logic [2:0] {
        REQ_READ       = 3'd0,
        REQ_WRITE      = 3'd1,
        REQ_RAISE_EXT  = 3'd2,
        REQ_RAISE_SRC  = 3'd3,
        REQ_RAISE_SUB  = 3'd4,
        REQ_UPDATE     = 3'd5
    } req_code_t;

    // Register map
    typedef enum logic [3:0] {
        REG_SRCPND    = 4'd0,
        REG_INTMOD    = 4'd1,
        REG_INTMSK    = 4'd2,
        REG_PRIORITY  = 4'd3,
        REG_INTPND    = 4'd4,
        REG_INTOFFSET = 4'd5,
        REG_SUBSRCPND = 4'd6,
        REG_INTSUBMSK = 4'd7,
        REG_EINTMASK  = 4'd8,
        REG_EINTPEND  = 4'd9
    } reg_code_t;

    localparam int SRC_W = 32;
    localparam int OFS_W = 5;
    localparam int SUB_W = 15;
    localparam int EXT_W = 24;

    localparam int UART0_BIT    = 28;
    localparam int UART1_BIT    = 23;
    localparam int UART2_BIT    = 15;
    localparam int ADC_BIT      = 31;
    localparam int EXT_LOW_BIT  = 4;
    localparam int EXT_HIGH_BIT = 5;

    localparam logic [SUB_W-1:0] SUB_TXD_ALL  = 15'h0092;
    localparam logic [SUB_W-1:0] SUB_UART0    = 15'h0007;
    localparam logic [SUB_W-1:0] SUB_UART1    = 15'h0038;
    localparam logic [SUB_W-1:0] SUB_UART2    = 15'h01C0;
    localparam logic [SUB_W-1:0] SUB_ADC      = 15'h0600;
    localparam logic [SUB_W-1:0] SUB_CLR_MASK = 15'h07FF;
    localparam logic [EXT_W-1:0] EXT_LOW_GRP  = 24'h0000F0;
    localparam logic [EXT_W-1:0] EXT_HIGH_GRP = 24'hFFFF00;
    localparam logic [EXT_W-1:0] EXT_CLR_MASK = 24'hFFFFF0;
    localparam logic [EXT_W-1:0] EXT_MASK_RST = 24'hFFFFF0;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  reg_sel;
        logic [31:0] write_data;
        logic [4:0]  line_index;
    } req_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        fiq_n;
        logic        irq_n;
    } rsp_item_t;

endpackage

// ===== hdl/arm_soc_interrupt_controller_core.sv =====
// Register-mapped interrupt controller. Each request transaction (read, write,
// line raise or update) produces exactly one response transaction carrying the
// read data (zero for anything but a read, all ones for an unmapped register)
// and the active-low FIQ/IRQ levels as they stand after the request. A request
// is captured in an input register, executed against the register file once the
// output slot is free and lands in the output register: one transaction per cycle
// sustained without output stalls, set by the single update/priority-encode pass
// between the two registers. The request side keeps accepting while a finished
// response waits on a stalled output, until the input register fills.
module arm_soc_interrupt_controller_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  aic_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output aic_pkg::rsp_item_t rsp
);
    import aic_pkg::*;

    // Pipeline registers
    logic      in_valid_reg;
    req_item_t in_item_reg;
    logic      out_valid_reg;
    rsp_item_t out_item_reg;

    // Register file
    logic [SRC_W-1:0] src_pnd_reg,  src_pnd_next;
    logic [SRC_W-1:0] mode_reg,     mode_next;
    logic [SRC_W-1:0] mask_reg,     mask_next;
    logic [SRC_W-1:0] prio_reg,     prio_next;
    logic [SRC_W-1:0] in_svc_reg,   in_svc_next;
    logic [OFS_W-1:0] offset_reg,   offset_next;
    logic [SUB_W-1:0] sub_pnd_reg,  sub_pnd_next;
    logic [SUB_W-1:0] sub_mask_reg, sub_mask_next;
    logic [EXT_W-1:0] ext_pnd_reg,  ext_pnd_next;
    logic [EXT_W-1:0] ext_mask_reg, ext_mask_next;
    logic             fiq_reg,      fiq_next;
    logic             irq_reg,      irq_next;
    logic [31:0]      rdata;

    logic out_free;
    logic exec;

    // Output slot is free when empty or being drained this cycle.
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign exec      = in_valid_reg && out_free;
    assign req_stall = in_valid_reg && !out_free;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    // Lowest set bit; caller guarantees a nonzero word when the result matters.
    function automatic logic [OFS_W-1:0] lowest_set(input logic [SRC_W-1:0] v);
        logic [OFS_W-1:0] idx;
        idx = '0;
        for (int i = SRC_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = OFS_W'(i);
            end
        end
        return idx;
    endfunction

    always_comb
    begin
        logic             do_update;
        logic [SUB_W-1:0] r;
        logic [EXT_W-1:0] e;
        logic [SRC_W-1:0] q;
        logic [SRC_W-1:0] line_bit;

        src_pnd_next  = src_pnd_reg;
        mode_next     = mode_reg;
        mask_next     = mask_reg;
        prio_next     = prio_reg;
        in_svc_next   = in_svc_reg;
        offset_next   = offset_reg;
        sub_pnd_next  = sub_pnd_reg;
        sub_mask_next = sub_mask_reg;
        ext_pnd_next  = ext_pnd_reg;
        ext_mask_next = ext_mask_reg;
        fiq_next      = fiq_reg;
        irq_next      = irq_reg;
        rdata         = '0;
        do_update     = 1'b0;
        r             = '0;
        e             = '0;
        q             = '0;
        line_bit      = SRC_W'(1) << in_item_reg.line_index;

        case (in_item_reg.req_type)
            REQ_READ:
            begin
                case (in_item_reg.reg_sel)
                    REG_SRCPND:    rdata = src_pnd_reg;
                    REG_INTMOD:    rdata = mode_reg;
                    REG_INTMSK:    rdata = mask_reg;
                    REG_PRIORITY:  rdata = prio_reg;
                    REG_INTPND, REG_INTOFFSET:
                    begin
                        // Reading either latches the lowest pending source, if any is pending.
                        if (src_pnd_reg != '0)
                        begin
                            offset_next = lowest_set(src_pnd_reg);
                            if (in_item_reg.reg_sel == REG_INTOFFSET)
                            begin
                                rdata = 32'(offset_next);
                            end
                            else
                            begin
                                rdata = 32'(1) << offset_next;
                            end
                        end
                        in_svc_next = SRC_W'(1) << offset_next;
                    end
                    REG_SUBSRCPND: rdata = 32'(sub_pnd_reg);
                    REG_INTSUBMSK: rdata = 32'(sub_mask_reg);
                    REG_EINTMASK:  rdata = 32'(ext_mask_reg);
                    REG_EINTPEND:  rdata = 32'(ext_pnd_reg);
                    default:       rdata = '1;
                endcase
            end
            REQ_WRITE:
            begin
                case (in_item_reg.reg_sel)
                    REG_SRCPND:
                    begin
                        src_pnd_next = src_pnd_reg & ~in_item_reg.write_data;
                        do_update    = 1'b1;
                    end
                    REG_INTMOD:    mode_next = in_item_reg.write_data;
                    REG_INTMSK:
                    begin
                        mask_next = in_item_reg.write_data;
                        do_update = 1'b1;
                    end
                    REG_PRIORITY:  prio_next = in_item_reg.write_data;
                    REG_INTPND:
                    begin
                        in_svc_next = in_svc_reg & ~in_item_reg.write_data;
                        offset_next = '0;
                    end
                    REG_SUBSRCPND:
                        sub_pnd_next = sub_pnd_reg & ~in_item_reg.write_data[SUB_W-1:0]
                                       & SUB_CLR_MASK;
                    REG_INTSUBMSK: sub_mask_next = in_item_reg.write_data[SUB_W-1:0];
                    REG_EINTMASK:  ext_mask_next = in_item_reg.write_data[EXT_W-1:0];
                    REG_EINTPEND:
                        ext_pnd_next = ext_pnd_reg & ~in_item_reg.write_data[EXT_W-1:0]
                                       & EXT_CLR_MASK;
                    default:       ;   // INTOFFSET is read-only; unmapped ignored
                endcase
            end
            REQ_RAISE_EXT:
                ext_pnd_next = ext_pnd_reg | line_bit[EXT_W-1:0];
            REQ_RAISE_SRC:
            begin
                src_pnd_next = src_pnd_reg | line_bit;
                do_update    = 1'b1;
            end
            REQ_RAISE_SUB:
            begin
                sub_pnd_next = sub_pnd_reg | line_bit[SUB_W-1:0];
                do_update    = 1'b1;
            end
            REQ_UPDATE:
                do_update = 1'b1;
            default: ;
        endcase

        if (do_update)
        begin
            // UART transmit sub-bits are forced on every update.
            sub_pnd_next = sub_pnd_next | SUB_TXD_ALL;
            r = sub_pnd_next & ~sub_mask_next;
            if ((r & SUB_UART0) != '0) src_pnd_next[UART0_BIT] = 1'b1;
            if ((r & SUB_UART1) != '0) src_pnd_next[UART1_BIT] = 1'b1;
            if ((r & SUB_UART2) != '0) src_pnd_next[UART2_BIT] = 1'b1;
            if ((r & SUB_ADC) != '0)   src_pnd_next[ADC_BIT]   = 1'b1;
            e = ext_pnd_next & ~ext_mask_next;
            if ((e & EXT_LOW_GRP) != '0)  src_pnd_next[EXT_LOW_BIT]  = 1'b1;
            if ((e & EXT_HIGH_GRP) != '0) src_pnd_next[EXT_HIGH_BIT] = 1'b1;
            q = src_pnd_next & ~mask_next;
            fiq_next = ((q & mode_next) == '0);
            irq_next = ((q & ~mode_next) == '0);
        end
    end

    // Control and register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            src_pnd_reg   <= '0;
            mode_reg      <= '0;
            mask_reg      <= '1;
            prio_reg      <= '0;
            in_svc_reg    <= '0;
            offset_reg    <= '0;
            sub_pnd_reg   <= '0;
            sub_mask_reg  <= '0;
            ext_pnd_reg   <= '0;
            ext_mask_reg  <= EXT_MASK_RST;
            fiq_reg       <= 1'b1;
            irq_reg       <= 1'b1;
        end
        else
        begin
            if (!req_stall)
            begin
                in_valid_reg <= req_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (exec)
            begin
                src_pnd_reg  <= src_pnd_next;
                mode_reg     <= mode_next;
                mask_reg     <= mask_next;
                prio_reg     <= prio_next;
                in_svc_reg   <= in_svc_next;
                offset_reg   <= offset_next;
                sub_pnd_reg  <= sub_pnd_next;
                sub_mask_reg <= sub_mask_next;
                ext_pnd_reg  <= ext_pnd_next;
                ext_mask_reg <= ext_mask_next;
                fiq_reg      <= fiq_next;
                irq_reg      <= irq_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            in_item_reg <= req;
        end
        if (exec)
        begin
            out_item_reg.read_data <= rdata;
            out_item_reg.fiq_n     <= fiq_next;
            out_item_reg.irq_n     <= irq_next;
        end
    end

endmodule
